// File: design/dmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types, constants and the microcode table for the matrix multiplier.
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int VALUE_W     = 36;
  localparam int IDX_OUT_W   = 3;
  localparam int CFG_W       = 4;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int OUT_DATA_W  = 48;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  localparam logic CMD_LOAD_A = 1'b0;
  localparam logic CMD_LOAD_B = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CELL,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_ADV,
    ST_DONE
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_K_MORE,
    C_OUT_BUSY,
    C_CELL_MORE
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  init;
    logic  cell_init;
    logic  mul;
    logic  acc;
    logic  emit;
    logic  advance;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic no_start;
    logic k_more;
    logic out_busy;
    logic cell_more;
  } flags_t;

  // one control word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{in_ready: 1'b0, init: 1'b0, cell_init: 1'b0, mul: 1'b0, acc: 1'b0,
          emit: 1'b0, advance: 1'b0, cond: C_NEVER, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        c.in_ready = 1'b1;
        c.cond     = C_NO_START;
        c.target   = ST_IDLE;
      end
      ST_INIT: c.init      = 1'b1;
      ST_CELL: c.cell_init = 1'b1;
      ST_READ: c.cond      = C_NEVER;
      ST_MUL:  c.mul       = 1'b1;
      ST_ACC: begin
        c.acc    = 1'b1;
        c.cond   = C_K_MORE;
        c.target = ST_READ;
      end
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = C_OUT_BUSY;
        c.target = ST_EMIT;
      end
      ST_ADV: begin
        c.advance = 1'b1;
        c.cond    = C_CELL_MORE;
        c.target  = ST_CELL;
      end
      ST_DONE: begin
        c.cond   = C_ALWAYS;
        c.target = ST_IDLE;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: design/dmm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dmm_ram
  import dmm_pkg::*;
#(
  parameter int DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [ELEM_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [ELEM_W-1:0] rdata
);

  logic signed [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/dmm_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_sequencer
// Step counter over the microcode table, with conditional jumps.
// ----------------------------------------------------------------------------
module dmm_sequencer
  import dmm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  step_t pc;
  step_t pc_next;
  logic  taken;

  // output decode
  always_comb begin
    ctrl = ucode(pc);
  end

  // next step
  always_comb begin
    case (ctrl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_START:  taken = flags.no_start;
      C_K_MORE:    taken = flags.k_more;
      C_OUT_BUSY:  taken = flags.out_busy;
      C_CELL_MORE: taken = flags.cell_more;
      default:     taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : step_t'(4'(pc) + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/dense_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// C = A * B for A m-by-n and B n-by-p, signed Q8.8 in, exact Q20.16 out.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Fields
// --------+-----+-----------------------------------------------------------
// s_*     | in  | tuser: command (0 = A, 1 = B); tdata: element Q8.8
// m_*     | out | tdata: product_value, row_index, col_index; tlast: last
// APB     | in  | rows_a @0x0, inner_size @0x4, cols_b @0x8 (4 bits each)
//
// Loads are taken one per cycle while the sequencer sits in its idle step.
// The load that completes B starts the compute; from then on the block takes
// no requests until the run ends, and output stalls lengthen the run: each
// product element costs one setup step, n passes of read/multiply/accumulate
// through the single multiplier and the one read port of each store, one
// emit step and one advance step.
// Reset (rst, synchronous) sets the dimensions to 8, clears both load
// counters and the output valid; the element stores are not cleared.
// A held result in the output register stalls only the emit step; the next
// load can be accepted while the last result of a run still waits.
// ----------------------------------------------------------------------------
module dense_matrix_multiply
  import dmm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // load requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ELEM_W-1:0]     s_tdata,   // [15:0] element
  input  logic                  s_tuser,   // [0] command
  // product requests
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [35:0] product_value,
                                           // [38:36] row_index,
                                           // [41:39] col_index, rest zero
  output logic                  m_tlast,   // last_flag
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // 4-bit registers cap the usable dimension at 15
  localparam int EFF_MAX = (MAX_DIM < 15) ? MAX_DIM : 15;
  localparam int DIM_W   = $clog2(EFF_MAX + 1);
  localparam int IDX_W   = $clog2(EFF_MAX);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PTR_W   = CNT_W + 1;   // room for one stride past the end

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_size;
  logic [CFG_W-1:0] cols_b;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= CFG_RESET;
      inner_size <= CFG_RESET;
      cols_b     <= CFG_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ROWS_A:     rows_a     <= pwdata[CFG_W-1:0];
        REG_INNER_SIZE: inner_size <= pwdata[CFG_W-1:0];
        REG_COLS_B:     cols_b     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A:     prdata = APB_DATA_W'(rows_a);
      REG_INNER_SIZE: prdata = APB_DATA_W'(inner_size);
      REG_COLS_B:     prdata = APB_DATA_W'(cols_b);
      default:        prdata = '0;
    endcase
  end

  // zero acts as one, anything above the cap acts as the cap
  function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] d;
    if (r == '0) begin
      d = CFG_W'(1);
    end else if (r > CFG_W'(EFF_MAX)) begin
      d = CFG_W'(EFF_MAX);
    end else begin
      d = r;
    end
    return DIM_W'(d);
  endfunction

  logic [DIM_W-1:0] dim_m;
  logic [DIM_W-1:0] dim_n;
  logic [DIM_W-1:0] dim_p;
  logic [CNT_W-1:0] a_size;
  logic [CNT_W-1:0] b_size;

  assign dim_m  = eff_dim(rows_a);
  assign dim_n  = eff_dim(inner_size);
  assign dim_p  = eff_dim(cols_b);
  assign a_size = CNT_W'(dim_m) * CNT_W'(dim_n);
  assign b_size = CNT_W'(dim_n) * CNT_W'(dim_p);

  // ---------------- sequencer ----------------
  ctrl_t  ctrl;
  flags_t flags;

  dmm_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign s_tready = ctrl.in_ready;

  // ---------------- load path ----------------
  logic             load;
  logic [CNT_W-1:0] left_count;
  logic [CNT_W-1:0] right_count;
  logic [CNT_W-1:0] left_pos;
  logic [CNT_W-1:0] right_pos;
  logic             we_a;
  logic             we_b;
  logic             start;

  assign load      = s_tvalid && s_tready;
  assign we_a      = load && (s_tuser == CMD_LOAD_A);
  assign we_b      = load && (s_tuser == CMD_LOAD_B);
  // a counter at or past its size (also after a shrink) wraps to the start
  assign left_pos  = (left_count  >= a_size) ? '0 : left_count;
  assign right_pos = (right_count >= b_size) ? '0 : right_count;
  assign start     = we_b && ((right_pos + CNT_W'(1)) == b_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
    end else if (ctrl.init) begin
      left_count  <= '0;
      right_count <= '0;
    end else begin
      if (we_a) begin
        left_count <= left_pos + CNT_W'(1);
      end
      if (we_b) begin
        right_count <= right_pos + CNT_W'(1);
      end
    end
  end

  // ---------------- compute datapath ----------------
  logic [IDX_W-1:0]          row_i;
  logic [IDX_W-1:0]          col_j;
  logic [IDX_W-1:0]          k;
  logic [PTR_W-1:0]          row_base;   // i*n
  logic [PTR_W-1:0]          a_addr;     // i*n + k
  logic [PTR_W-1:0]          b_addr;     // k*p + j
  logic signed [ELEM_W-1:0]  a_q;
  logic signed [ELEM_W-1:0]  b_q;
  logic signed [PROD_W-1:0]  prod;
  logic signed [VALUE_W-1:0] acc;
  logic                      last_cell;
  logic                      out_busy;
  logic                      out_load;

  dmm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_left (
    .clk   (clk),
    .we    (we_a),
    .waddr (left_pos[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (a_addr[ADDR_W-1:0]),
    .rdata (a_q)
  );

  dmm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_right (
    .clk   (clk),
    .we    (we_b),
    .waddr (right_pos[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (b_addr[ADDR_W-1:0]),
    .rdata (b_q)
  );

  assign last_cell = (DIM_W'(row_i) == dim_m - DIM_W'(1)) &&
                     (DIM_W'(col_j) == dim_p - DIM_W'(1));
  assign out_busy  = m_tvalid && !m_tready;
  assign out_load  = ctrl.emit && !out_busy;

  assign flags.no_start  = !start;
  assign flags.k_more    = DIM_W'(k) != dim_n - DIM_W'(1);
  assign flags.out_busy  = out_busy;
  assign flags.cell_more = !last_cell;

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      row_i    <= '0;
      col_j    <= '0;
      row_base <= '0;
    end else if (ctrl.advance) begin
      if (DIM_W'(col_j) == dim_p - DIM_W'(1)) begin
        col_j    <= '0;
        row_i    <= row_i + IDX_W'(1);
        row_base <= row_base + PTR_W'(dim_n);
      end else begin
        col_j <= col_j + IDX_W'(1);
      end
    end

    if (ctrl.cell_init) begin
      k      <= '0;
      acc    <= '0;
      a_addr <= row_base;
      b_addr <= PTR_W'(col_j);
    end else if (ctrl.acc) begin
      k      <= k + IDX_W'(1);
      acc    <= acc + VALUE_W'(prod);
      a_addr <= a_addr + PTR_W'(1);
      b_addr <= b_addr + PTR_W'(dim_p);
    end

    if (ctrl.mul) begin
      prod <= a_q * b_q;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(OUT_DATA_W - VALUE_W - 2 * IDX_OUT_W)'(0),
                  IDX_OUT_W'(col_j), IDX_OUT_W'(row_i), acc};
      m_tlast <= last_cell;
    end
  end

endmodule

// File: design/dmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_checker
// Port-level checks for dense_matrix_multiply, attached by bind.
// ----------------------------------------------------------------------------
module dmm_checker
  import dmm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // no result left over from before reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // a pending result inside a run means compute is still busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("load accepted in the middle of a run");

  // after a non-final result leaves, the run goes on without loads
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
    else $error("ready raised before the run ended");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dense_matrix_multiply.
// Loads A and B elements over the stream input, sets the three dimensions over
// APB while the block is idle, and checks every product element (value, row,
// column, last) in order against a predictor that runs beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import dmm_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int SETTLE_CYCLES = 8;  // ADV/DONE steps after the last product

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last;
  } product_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [ELEM_W-1:0]     s_tdata;   // [15:0] element
  logic                  s_tuser;   // [0] command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [35:0] value, [38:36] row, [41:39] col
  logic                  m_tlast;   // last
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dense_matrix_multiply DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: dimension registers, element stores, load positions.
  logic [CFG_W-1:0]         dim_reg [3];
  logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
  logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];
  bit                       a_written [STORE_DEPTH];
  int unsigned              a_pos;
  int unsigned              b_pos;
  int unsigned              runs_emitted;

  product_t    pending_products[$];
  int unsigned mismatches;
  int unsigned loads_sent;
  int unsigned load_gap_pct;
  int unsigned accept_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("dense_matrix_multiply verification failed");
    $finish;
  end

  // Output stall pattern, redrawn every cycle.
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= accept_stall_pct);
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
    return r;
  endfunction

  // every A position that a product reads has been written since reset
  function automatic bit a_loaded();
    int unsigned a_size;
    a_size = eff_dim(dim_reg[REG_ROWS_A]) * eff_dim(dim_reg[REG_INNER_SIZE]);
    for (int unsigned q = 0; q < a_size; q++)
      if (!a_written[q]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit b_completes_next();
    int unsigned b_size;
    int unsigned pos;
    b_size = eff_dim(dim_reg[REG_INNER_SIZE]) * eff_dim(dim_reg[REG_COLS_B]);
    pos = (b_pos >= b_size) ? 0 : b_pos;
    return (pos + 1 == b_size);
  endfunction

  function automatic void predict_load(input logic cmd, input logic [ELEM_W-1:0] elem);
    int unsigned m, n, p, pos;
    logic signed [VALUE_W-1:0] sum;
    product_t prod;
    m = eff_dim(dim_reg[REG_ROWS_A]);
    n = eff_dim(dim_reg[REG_INNER_SIZE]);
    p = eff_dim(dim_reg[REG_COLS_B]);
    if (cmd == CMD_LOAD_A) begin
      pos = (a_pos >= m * n) ? 0 : a_pos;
      a_mem[pos] = elem;
      a_written[pos] = 1'b1;
      a_pos = pos + 1;
      return;
    end
    pos = (b_pos >= n * p) ? 0 : b_pos;
    b_mem[pos] = elem;
    b_pos = pos + 1;
    if (b_pos != n * p) return;
    // B complete: whole product in row-major order, sums wrap at 36 bits
    for (int unsigned i = 0; i < m; i++) begin
      for (int unsigned j = 0; j < p; j++) begin
        sum = '0;
        for (int unsigned k = 0; k < n; k++)
          sum = sum + a_mem[i * n + k] * b_mem[k * p + j];
        prod.value = sum;
        prod.row   = i[IDX_OUT_W-1:0];
        prod.col   = j[IDX_OUT_W-1:0];
        prod.last  = (i == m - 1) && (j == p - 1);
        pending_products.push_back(prod);
      end
    end
    a_pos = 0;
    b_pos = 0;
    runs_emitted++;
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    product_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: product with none expected: value %h row %0d col %0d last %b",
                 $time, m_tdata[35:0], m_tdata[38:36], m_tdata[41:39], m_tlast);
        mismatches++;
      end else begin
        want = pending_products.pop_front();
        if (m_tdata[35:0] !== want.value) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, want.value, m_tdata[35:0]);
          mismatches++;
        end
        if (m_tdata[38:36] !== want.row) begin
          $display("%0t: row mismatch: expected %0d, actual %0d",
                   $time, want.row, m_tdata[38:36]);
          mismatches++;
        end
        if (m_tdata[41:39] !== want.col) begin
          $display("%0t: col mismatch: expected %0d, actual %0d",
                   $time, want.col, m_tdata[41:39]);
          mismatches++;
        end
        if (m_tdata[OUT_DATA_W-1:42] !== '0) begin
          $display("%0t: pad bits mismatch: expected 0, actual %h",
                   $time, m_tdata[OUT_DATA_W-1:42]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  // Called and returns at a falling edge; tvalid stays high on return.
  task automatic send_load(input logic cmd, input logic [ELEM_W-1:0] elem);
    while ($urandom_range(0, 99) < load_gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= ELEM_W'($urandom());
      s_tuser  <= 1'($urandom());
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= elem;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_load(cmd, elem);
    loads_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid, let every expected product arrive, then pad for the tail
  // steps of the sequencer. Returns at a falling edge.
  task automatic drain_products();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Setup then access phase; only while the block is idle.
  task automatic write_dim(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    logic [APB_DATA_W-1:0] fill;
    fill = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {fill[APB_DATA_W-1:CFG_W], val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dim_reg[idx] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] m, n, p);
    drain_products();
    write_dim(REG_ROWS_A, m);
    write_dim(REG_INNER_SIZE, n);
    write_dim(REG_COLS_B, p);
  endtask

  function automatic logic [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // ------------------------------------------------------------------- tests
  // Zero acts as 1, anything above 8 as 8: a 1x8 by 8x1 dot product of the
  // most negative element with itself, the largest positive sum.
  task automatic test_clamped_dims();
    set_dims(4'd0, 4'd15, 4'd0);
    repeat (8) send_load(CMD_LOAD_A, 16'h8000);
    repeat (8) send_load(CMD_LOAD_B, 16'h8000);
  endtask

  // Third A load wraps onto position 0. One B load gives nothing; then B
  // shrinks to one element so the B counter sits beyond it and restarts.
  task automatic test_wrap_and_shrink();
    set_dims(4'd2, 4'd1, 4'd2);
    send_load(CMD_LOAD_A, 16'h0100);
    send_load(CMD_LOAD_A, 16'h7FFF);
    send_load(CMD_LOAD_A, 16'h8000);
    send_load(CMD_LOAD_B, 16'h7FFF);
    drain_products();
    write_dim(REG_COLS_B, 4'd1);
    send_load(CMD_LOAD_B, 16'h8000);
  endtask

  // Counters are back at zero after a run: a fresh run from position 0.
  task automatic test_counter_restart();
    send_load(CMD_LOAD_A, 16'h0001);
    send_load(CMD_LOAD_A, 16'hFFFF);
    send_load(CMD_LOAD_B, 16'hFFFF);
  endtask

  task automatic pick_dims();
    logic [CFG_W-1:0] raw [3];
    for (int d = 0; d < 3; d++) begin
      case ($urandom_range(0, 9))
        0:       raw[d] = 4'd0;
        1:       raw[d] = 4'd8;
        2:       raw[d] = CFG_W'($urandom_range(9, 15));
        default: raw[d] = CFG_W'($urandom_range(1, 3));
      endcase
    end
    // keep a run short: a wide product goes with a thin inner size
    if (eff_dim(raw[0]) * eff_dim(raw[1]) + eff_dim(raw[1]) * eff_dim(raw[2]) > 40)
      raw[1] = CFG_W'($urandom_range(0, 1));
    set_dims(raw[0], raw[1], raw[2]);
  endtask

  // Mostly complete A then B loads up to a product; the rest is loose loads
  // that leave counters part way (B is never completed onto an unloaded A).
  task automatic test_random_traffic(input int unsigned gap_pct, stall_pct,
                                     input int unsigned n_loads);
    int unsigned first;
    int unsigned start_runs;
    int unsigned a_size;
    logic cmd;
    load_gap_pct     = gap_pct;
    accept_stall_pct = stall_pct;
    first = loads_sent;
    while (loads_sent - first < n_loads) begin
      if ($urandom_range(0, 3) == 0) pick_dims();
      if ($urandom_range(0, 3) != 0) begin
        a_size = eff_dim(dim_reg[REG_ROWS_A]) * eff_dim(dim_reg[REG_INNER_SIZE]);
        repeat (a_size) send_load(CMD_LOAD_A, random_element());
        start_runs = runs_emitted;
        while (runs_emitted == start_runs) send_load(CMD_LOAD_B, random_element());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          cmd = 1'($urandom_range(0, 1));
          if (cmd == CMD_LOAD_B && b_completes_next() && !a_loaded()) cmd = CMD_LOAD_A;
          send_load(cmd, random_element());
        end
      end
    end
  endtask

  // -------------------------------------------------------------------- main
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_LOAD_A;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    for (int q = 0; q < 3; q++) dim_reg[q] = CFG_RESET;
    for (int q = 0; q < STORE_DEPTH; q++) a_written[q] = 1'b0;
    a_pos            = 0;
    b_pos            = 0;
    runs_emitted     = 0;
    mismatches       = 0;
    loads_sent       = 0;
    load_gap_pct     = 20;
    accept_stall_pct = 20;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_clamped_dims();
    test_wrap_and_shrink();
    test_counter_restart();
    test_random_traffic(34, 49, 28);
    test_random_traffic(49, 34, 28);
    test_random_traffic(0, 0, 28);
    drain_products();

    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("dense_matrix_multiply verification clean");
    end else begin
      $display("dense_matrix_multiply verification failed");
    end
    $finish;
  end

endmodule
